// ===== hdl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL: same-cycle and next-cycle implication.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lpht_pkg.sv =====
// -----------------------------------------------------------------------------
// lpht_pkg
// Opcodes, slot marks, status codes and controller states of the hash table.
// -----------------------------------------------------------------------------
package lpht_pkg;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_SEARCH  = 2'd1,
      OP_DEL_KEY = 2'd2,
      OP_DEL_IDX = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_USED  = 2'd1,
      MARK_GONE  = 2'd2,
      MARK_RSVD  = 2'd3
   } mark_type;

   typedef enum logic [2:0] {
      STAT_INSERTED   = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_FOUND      = 3'd2,
      STAT_MISSING    = 3'd3,
      STAT_DELETED    = 3'd4,
      STAT_SLOT_EMPTY = 3'd5,
      STAT_SLOT_GONE  = 3'd6,
      STAT_RSVD       = 3'd7
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_PROBE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   localparam int unsigned KEY_W    = 32;
   localparam int unsigned IDX_W    = 4;
   localparam int unsigned HASH_DIG = 4;   // bytes of the key folded into the home slot

endpackage

// ===== hdl/linear_probe_hash_table.sv =====
// -----------------------------------------------------------------------------
// Sequence: insert/search/delete-by-key: key fold (S_HASH), then probes (S_PROBE),
//   then result (S_DONE); delete-at-index: S_PROBE, S_DONE; index out of range: S_DONE.
// Flow: one request in flight; the next one is taken once its result has moved to
//   the output register and the controller is back in S_IDLE; a held response delays that.
// Reset: synchronous; a clearing pass marks every slot empty,
//   req_tready stays low until it ends.
// -----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing, stored in one slot RAM.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] key, [35:32] slot_index, [39:36] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] where, [35:4] stored_key, [39:36] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   // slot address width and stored key width
   localparam int AW = $clog2(SLOTS);
   localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int VW = AW + 8;
   localparam int MW = KW + 2;     // RAM word: {key, mark}
   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << KEY_BITS) - 64'd1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

   // home slot fold: remainder of {r, b} by SLOTS, one restoring step per bit
   function automatic logic [AW-1:0] fold_byte(logic [AW-1:0] r, logic [7:0] b);
      logic [VW-1:0] v;
      v = {r, b};
      for (int j = 7; j >= 0; j--) begin
         if (v >= (VW'(SLOTS) << j)) begin
            v = v - (VW'(SLOTS) << j);
         end
      end
      return v[AW-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // control and working registers
   // ---------------------------------------------------------------------------
   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [AW-1:0]        ptr_ff, ptr_in;      // probe slot, also clear-pass address
   logic [AW-1:0]        cnt_ff, cnt_in;      // probes done in this lap
   logic [AW-1:0]        rem_ff, rem_in;      // running remainder of the key fold
   logic [1:0]           dig_ff, dig_in;      // key byte being folded, MSB first
   status_type           res_stat_ff, res_stat_in;
   logic [IDX_W-1:0]     res_where_ff, res_where_in;
   logic [KEY_W-1:0]     res_key_ff, res_key_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_stat_ff, rsp_stat_in;
   logic [IDX_W-1:0]     rsp_where_ff, rsp_where_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;

   // RAM port signals
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [MW-1:0]        wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [MW-1:0]        rd_data;

   // request fields
   logic [KEY_W-1:0]     req_key;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_fire;
   logic                 idx_ok;

   // probe decode
   mark_type             slot_mark;
   logic [KW-1:0]        slot_key;
   logic                 slot_hit;
   logic                 lap_end;
   logic [7:0]           fold_in;
   logic [AW-1:0]        fold_out;
   logic [AW-1:0]        ptr_next;

   assign req_key  = req_tdata[31:0] & KEY_MASK;
   assign req_idx  = req_tdata[35:32];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign idx_ok   = (32'(req_idx) < 32'(SLOTS));

   assign slot_mark = mark_type'(rd_data[1:0]);
   assign slot_key  = rd_data[MW-1:2];
   assign slot_hit  = (slot_mark == MARK_USED) && (slot_key == key_ff[KW-1:0]);
   assign lap_end   = (cnt_ff == LAST_SLOT);
   assign ptr_next  = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;

   assign fold_in   = 8'(key_ff >> {~dig_ff, 3'b000});
   assign fold_out  = fold_byte(rem_ff, fold_in);

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      dig_in       = dig_ff;
      res_stat_in  = res_stat_ff;
      res_where_in = res_where_ff;
      res_key_in   = res_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_where_in = rsp_where_ff;
      rsp_key_in   = rsp_key_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      case (state_ff)
         S_CLEAR: begin
            // write every slot empty, one per cycle
            wr_en  = 1'b1;
            ptr_in = ptr_next;
            if (ptr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in  = op_type'(req_tuser);
               key_in = req_key;
               cnt_in = '0;
               rem_in = '0;
               dig_in = '0;
               if (op_type'(req_tuser) != OP_DEL_IDX) begin
                  state_in = S_HASH;
               end else if (idx_ok) begin
                  // single probe at the given slot
                  ptr_in   = AW'(req_idx);
                  rd_en    = 1'b1;
                  rd_addr  = AW'(req_idx);
                  state_in = S_PROBE;
               end else begin
                  res_stat_in  = STAT_SLOT_EMPTY;
                  res_where_in = '0;
                  res_key_in   = '0;
                  state_in     = S_DONE;
               end
            end
         end

         S_HASH: begin
            rem_in = fold_out;
            dig_in = dig_ff + 1'b1;
            if (dig_ff == 2'(HASH_DIG - 1)) begin
               // home slot known: first probe read goes out now
               ptr_in   = fold_out;
               rd_en    = 1'b1;
               rd_addr  = fold_out;
               state_in = S_PROBE;
            end
         end

         S_PROBE: begin
            res_where_in = 4'(ptr_ff);
            res_key_in   = '0;
            case (op_ff)
               OP_INSERT: begin
                  if (slot_mark == MARK_EMPTY) begin
                     wr_en       = 1'b1;
                     wr_data     = {key_ff[KW-1:0], MARK_USED};
                     res_stat_in = STAT_INSERTED;
                     state_in    = S_DONE;
                  end else if (lap_end) begin
                     res_stat_in  = STAT_FULL;
                     res_where_in = '0;
                     state_in     = S_DONE;
                  end
               end
               OP_SEARCH, OP_DEL_KEY: begin
                  if (slot_mark == MARK_EMPTY) begin
                     res_stat_in  = STAT_MISSING;
                     res_where_in = '0;
                     state_in     = S_DONE;
                  end else if (slot_hit) begin
                     res_key_in = key_ff;
                     state_in   = S_DONE;
                     if (op_ff == OP_DEL_KEY) begin
                        wr_en       = 1'b1;
                        wr_data     = {slot_key, MARK_GONE};
                        res_stat_in = STAT_DELETED;
                     end else begin
                        res_stat_in = STAT_FOUND;
                     end
                  end else if (lap_end) begin
                     res_stat_in  = STAT_MISSING;
                     res_where_in = '0;
                     state_in     = S_DONE;
                  end
               end
               OP_DEL_IDX: begin
                  state_in = S_DONE;
                  if (slot_mark == MARK_EMPTY) begin
                     res_stat_in  = STAT_SLOT_EMPTY;
                     res_where_in = '0;
                  end else if (slot_mark == MARK_USED) begin
                     wr_en       = 1'b1;
                     wr_data     = {slot_key, MARK_GONE};
                     res_stat_in = STAT_DELETED;
                     res_key_in  = 32'(slot_key);
                  end else begin
                     res_stat_in  = STAT_SLOT_GONE;
                     res_where_in = '0;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
            // keep probing: next slot read overlaps this decision
            if (state_in == S_PROBE) begin
               ptr_in  = ptr_next;
               cnt_in  = cnt_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = ptr_next;
            end
         end

         S_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_where_in = res_where_ff;
               rsp_key_in   = res_key_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      dig_ff       <= dig_in;
      res_stat_ff  <= res_stat_in;
      res_where_ff <= res_where_in;
      res_key_ff   <= res_key_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_where_ff <= rsp_where_in;
      rsp_key_ff   <= rsp_key_in;
   end

   // slot store: {key, mark} per slot
   lpht_ram #(
      .WIDTH (MW),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_key_ff, rsp_where_ff};
   assign rsp_tuser  = rsp_stat_ff;

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   `ASSERT_IMPLY(a_wr_state, clock, reset, wr_en,
      (state_ff == S_CLEAR) || (state_ff == S_PROBE), "slot write outside clear or probe")
   `ASSERT_NEXT(a_req_start, clock, reset, req_fire,
      (state_ff == S_HASH) || (state_ff == S_PROBE) || (state_ff == S_DONE),
      "accepted request did not start")
   `ASSERT_IMPLY(a_where_zero, clock, reset,
      rsp_tvalid && ((rsp_tuser == STAT_FULL) || (rsp_tuser == STAT_MISSING)),
      (rsp_tdata[3:0] == 4'd0) && (rsp_tdata[35:4] == 32'd0), "miss result carries data")
   `ASSERT_IMPLY(a_probe_read, clock, reset,
      (state_ff == S_PROBE) && (state_in == S_PROBE), rd_en, "probe continues without read")

endmodule

// ===== hdl/lpht_ram.sv =====
// -----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
